[hdl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometer compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  // field widths
  localparam int unsigned CalW   = 16;
  localparam int unsigned RawW   = 24;
  localparam int unsigned DtW    = 25;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PresW  = 18;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned NumCal = 6;

  // back end pipeline depth, output register included
  localparam int unsigned NumStages = 8;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // temperature breakpoints, both relative to the 20.00 degC reference
  localparam logic signed [TempW-1:0] TempBase   = 19'sd2000;
  localparam logic signed [TempW-1:0] VeryLowOfs = 19'sd3500;

  // pressure saturation limit
  localparam logic [PresW-1:0] PresMax = {PresW{1'b1}};

  // register map, word index of each calibration word
  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_e;

  // factory calibration words
  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

  // one queued sample: raw pressure and temperature difference
  typedef struct packed {
    logic        [RawW-1:0] d1;
    logic signed [DtW-1:0]  dt;
  } q_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hdl/bsc_cfg.sv]
// ----------------------------------------------------------------------------
// bsc_cfg
// APB register file for the six calibration words, with read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bsc_pkg::AddrW-1:0] paddr,
  input  wire logic [bsc_pkg::DataW-1:0] pwdata,
  output logic      [bsc_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output bsc_pkg::cal_t                  cal_o
);

  bsc_pkg::cal_t     cal_q, cal_d;
  bsc_pkg::cfg_reg_e reg_idx;
  logic              wr_en;
  logic [bsc_pkg::CalW-1:0] rd_word;

  assign reg_idx = bsc_pkg::cfg_reg_e'(paddr[bsc_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // write decode, addresses past the map are dropped
  always_comb begin
    cal_d = cal_q;
    if (wr_en) begin
      unique case (reg_idx)
        bsc_pkg::REG_C1: cal_d.c1 = pwdata[bsc_pkg::CalW-1:0];
        bsc_pkg::REG_C2: cal_d.c2 = pwdata[bsc_pkg::CalW-1:0];
        bsc_pkg::REG_C3: cal_d.c3 = pwdata[bsc_pkg::CalW-1:0];
        bsc_pkg::REG_C4: cal_d.c4 = pwdata[bsc_pkg::CalW-1:0];
        bsc_pkg::REG_C5: cal_d.c5 = pwdata[bsc_pkg::CalW-1:0];
        bsc_pkg::REG_C6: cal_d.c6 = pwdata[bsc_pkg::CalW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      bsc_pkg::REG_C1: rd_word = cal_q.c1;
      bsc_pkg::REG_C2: rd_word = cal_q.c2;
      bsc_pkg::REG_C3: rd_word = cal_q.c3;
      bsc_pkg::REG_C4: rd_word = cal_q.c4;
      bsc_pkg::REG_C5: rd_word = cal_q.c5;
      bsc_pkg::REG_C6: rd_word = cal_q.c6;
      default:         rd_word = '0;
    endcase
  end

  assign prdata = {{(bsc_pkg::DataW - bsc_pkg::CalW){1'b0}}, rd_word};
  assign cal_o  = cal_q;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

endmodule

`default_nettype wire

[hdl/bsc_front.sv]
// ----------------------------------------------------------------------------
// bsc_front
// Input stage: takes a sample pair, forms the temperature difference and
// hands the entry to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [bsc_pkg::RawW-1:0] raw_pressure_i,
  input  wire logic [bsc_pkg::RawW-1:0] raw_temperature_i,
  input  wire logic [bsc_pkg::CalW-1:0] ref_temp_i,
  input  bsc_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output bsc_pkg::q_entry_t             entry_o
);

  logic              hold_vld_q, hold_vld_d;
  bsc_pkg::q_entry_t hold_q, hold_d;
  logic              accept;

  // stall only while the holding register cannot drain
  assign in_stall_o = hold_vld_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = hold_vld_q && !q_stat_i.full;
  assign entry_o    = hold_q;

  // dT = D2 - C5 * 256
  always_comb begin
    hold_d.d1 = raw_pressure_i;
    hold_d.dt = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, ref_temp_i, 8'd0});
  end

  assign hold_vld_d = accept || (hold_vld_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
    end
  end

  // payload holding register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= hold_d;
    end
  end

endmodule

`default_nettype wire

[hdl/bsc_queue.sv]
// ----------------------------------------------------------------------------
// bsc_queue
// Small FIFO decoupling the input stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_queue #(
  parameter int unsigned Depth = bsc_pkg::QueueDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  bsc_pkg::q_entry_t entry_i,
  input  wire logic         pop_i,
  output bsc_pkg::q_entry_t entry_o,
  output bsc_pkg::q_stat_t  stat_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsc_pkg::q_entry_t entries_q [Depth];
  logic [IdxW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign entry_o      = entries_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

[hdl/bsc_back.sv]
// ----------------------------------------------------------------------------
// bsc_back
// Eight stage arithmetic pipeline: first order compensation, low temperature
// correction, pressure product and saturation, ending in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  bsc_pkg::cal_t                     cal_i,
  input  bsc_pkg::q_entry_t                 entry_i,
  input  bsc_pkg::q_stat_t                  q_stat_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [bsc_pkg::TempW-1:0]  temperature_centi_o,
  output logic        [bsc_pkg::PresW-1:0]  pressure_centi_o
);

  localparam int unsigned NS = bsc_pkg::NumStages;

  logic          en;
  logic [NS-1:0] vld_q, vld_d;

  // stage 1: products of dT
  logic        [23:0] s1_d1_q;
  logic signed [40:0] s1_mt_q, s1_mt_d;
  logic signed [40:0] s1_moff_q, s1_moff_d;
  logic signed [40:0] s1_msens_q, s1_msens_d;
  logic signed [48:0] s1_msq_q, s1_msq_d;

  // stage 2: first order terms
  logic        [23:0] s2_d1_q;
  logic signed [18:0] s2_temp_q, s2_temp_d;
  logic signed [17:0] s2_d_q, s2_d_d;
  logic signed [18:0] s2_e_q, s2_e_d;
  logic signed [39:0] s2_off_q, s2_off_d;
  logic signed [39:0] s2_sens_q, s2_sens_d;
  logic        [16:0] s2_t2_q;
  logic signed [18:0] d_ext;

  // stage 3: squares for the second order terms
  logic        [23:0] s3_d1_q;
  logic signed [18:0] s3_temp_q, s3_temp_d;
  logic signed [39:0] s3_off_q;
  logic signed [39:0] s3_sens_q;
  logic               s3_low_q, s3_low_d;
  logic               s3_vlow_q, s3_vlow_d;
  logic        [34:0] s3_dd_q;
  logic        [35:0] s3_ee_q;
  logic signed [35:0] sq_d;
  logic signed [37:0] sq_e;

  // stage 4: second order offset and sensitivity
  logic        [23:0] s4_d1_q;
  logic signed [18:0] s4_temp_q;
  logic signed [39:0] s4_off_q;
  logic signed [39:0] s4_sens_q;
  logic        [37:0] s4_off2_q, s4_off2_d;
  logic        [36:0] s4_sens2_q, s4_sens2_d;
  logic        [37:0] dd5;
  logic        [38:0] ee7;
  logic        [39:0] ee11;
  logic        [38:0] off2_sum;
  logic        [39:0] sens2_sum;

  // stage 5: corrected offset and sensitivity
  logic        [23:0] s5_d1_q;
  logic signed [18:0] s5_temp_q;
  logic signed [39:0] s5_off_q;
  logic signed [39:0] s5_sens_q;

  // stage 6: split pressure product
  logic signed [18:0] s6_temp_q;
  logic signed [39:0] s6_off_q;
  logic signed [44:0] s6_ph_q, s6_ph_d;
  logic        [43:0] s6_pl_q, s6_pl_d;

  // stage 7: recombined product scaled by 2^-21
  logic signed [18:0] s7_temp_q;
  logic signed [39:0] s7_off_q;
  logic signed [42:0] s7_q_q;
  logic signed [63:0] prod;

  // stage 8: output register
  logic signed [18:0] s8_temp_q;
  logic        [17:0] s8_pres_q, s8_pres_d;
  logic signed [43:0] diff;
  logic signed [28:0] p_raw;

  // whole pipeline advances unless the output slot is full and stalled
  assign en    = !vld_q[NS-1] || !out_stall_i;
  assign pop_o = en && !q_stat_i.empty;
  assign vld_d = {vld_q[NS-2:0], pop_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // stage 1 products
  always_comb begin
    s1_mt_d    = entry_i.dt * $signed({1'b0, cal_i.c6});
    s1_moff_d  = entry_i.dt * $signed({1'b0, cal_i.c4});
    s1_msens_d = entry_i.dt * $signed({1'b0, cal_i.c3});
    s1_msq_d   = entry_i.dt * entry_i.dt;
  end

  // stage 2 first order compensation, floor shifts are bit selects
  always_comb begin
    s2_d_d    = s1_mt_q[40:23];
    d_ext     = {s2_d_d[17], s2_d_d};
    s2_temp_d = d_ext + bsc_pkg::TempBase;
    s2_e_d    = d_ext + bsc_pkg::VeryLowOfs;
    s2_off_d  = $signed({8'd0, cal_i.c2, 16'd0})
              + $signed({{6{s1_moff_q[40]}}, s1_moff_q[40:7]});
    s2_sens_d = $signed({9'd0, cal_i.c1, 15'd0})
              + $signed({{7{s1_msens_q[40]}}, s1_msens_q[40:8]});
  end

  // stage 3 squares and the T2 correction
  always_comb begin
    s3_low_d  = s2_d_q[17];
    s3_vlow_d = s2_e_q[18];
    s3_temp_d = s3_low_d ? (s2_temp_q - $signed({2'd0, s2_t2_q})) : s2_temp_q;
    sq_d      = s2_d_q * s2_d_q;
    sq_e      = s2_e_q * s2_e_q;
  end

  // stage 4 second order terms by shift and add
  always_comb begin
    dd5       = {1'b0, s3_dd_q, 2'd0} + {3'd0, s3_dd_q};
    ee7       = {s3_ee_q, 3'd0} - {3'd0, s3_ee_q};
    ee11      = {1'b0, s3_ee_q, 3'd0} + {3'd0, s3_ee_q, 1'b0} + {4'd0, s3_ee_q};
    off2_sum  = {2'd0, dd5[37:1]} + (s3_vlow_q ? ee7 : 39'd0);
    sens2_sum = {4'd0, dd5[37:2]} + (s3_vlow_q ? {1'b0, ee11[39:1]} : 40'd0);
    s4_off2_d  = s3_low_q ? off2_sum[37:0]  : 38'd0;
    s4_sens2_d = s3_low_q ? sens2_sum[36:0] : 37'd0;
  end

  // stage 6 pressure product split at bit 20 of the sensitivity
  always_comb begin
    s6_ph_d = $signed(s5_sens_q[39:20]) * $signed({1'b0, s5_d1_q});
    s6_pl_d = s5_sens_q[19:0] * s5_d1_q;
  end

  // stage 7 recombine
  assign prod = $signed({s6_ph_q[43:0], 20'd0}) + $signed({20'd0, s6_pl_q});

  // stage 8 subtract offset, scale and saturate
  always_comb begin
    diff  = $signed({s7_q_q[42], s7_q_q}) - $signed({{4{s7_off_q[39]}}, s7_off_q});
    p_raw = diff[43:15];
    priority if (p_raw[28]) begin
      s8_pres_d = '0;
    end else if (|p_raw[27:18]) begin
      s8_pres_d = bsc_pkg::PresMax;
    end else begin
      s8_pres_d = p_raw[17:0];
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d1_q    <= entry_i.d1;
      s1_mt_q    <= s1_mt_d;
      s1_moff_q  <= s1_moff_d;
      s1_msens_q <= s1_msens_d;
      s1_msq_q   <= s1_msq_d;

      s2_d1_q    <= s1_d1_q;
      s2_temp_q  <= s2_temp_d;
      s2_d_q     <= s2_d_d;
      s2_e_q     <= s2_e_d;
      s2_off_q   <= s2_off_d;
      s2_sens_q  <= s2_sens_d;
      s2_t2_q    <= s1_msq_q[47:31];

      s3_d1_q    <= s2_d1_q;
      s3_temp_q  <= s3_temp_d;
      s3_off_q   <= s2_off_q;
      s3_sens_q  <= s2_sens_q;
      s3_low_q   <= s3_low_d;
      s3_vlow_q  <= s3_vlow_d;
      s3_dd_q    <= sq_d[34:0];
      s3_ee_q    <= sq_e[35:0];

      s4_d1_q    <= s3_d1_q;
      s4_temp_q  <= s3_temp_q;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_off2_q  <= s4_off2_d;
      s4_sens2_q <= s4_sens2_d;

      s5_d1_q    <= s4_d1_q;
      s5_temp_q  <= s4_temp_q;
      s5_off_q   <= s4_off_q - $signed({2'd0, s4_off2_q});
      s5_sens_q  <= s4_sens_q - $signed({3'd0, s4_sens2_q});

      s6_temp_q  <= s5_temp_q;
      s6_off_q   <= s5_off_q;
      s6_ph_q    <= s6_ph_d;
      s6_pl_q    <= s6_pl_d;

      s7_temp_q  <= s6_temp_q;
      s7_off_q   <= s6_off_q;
      s7_q_q     <= prod[63:21];

      s8_temp_q  <= s7_temp_q;
      s8_pres_q  <= s8_pres_d;
    end
  end

  assign out_valid_o         = vld_q[NS-1];
  assign temperature_centi_o = s8_temp_q;
  assign pressure_centi_o    = s8_pres_q;

endmodule

`default_nettype wire

[hdl/baro_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second order temperature compensation for a 24-bit barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration words C1..C6 over the APB port (word addresses
//   0x00..0x14) while the block is idle; they read back as written.
//   Each input transfer carries one raw pressure and one raw temperature
//   conversion; each gives exactly one output transfer with temperature in
//   0.01 degC and pressure in 0.01 mbar, clamped to 0..262143.
//   Throughput: one sample pair per clock, set by the eight stage arithmetic
//   pipeline which advances every cycle its output register can move.
//   A sample passes the input stage holding register, a queue entry and the
//   eight pipeline stages; the last of these is the output register.
//   Out stall freezes the pipeline with the result held in the output
//   register; the queue between input stage and pipeline keeps taking
//   samples until it and the holding register fill, then in_stall_o rises.
//   Reset clears the calibration words to zero and empties all stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation #(
  parameter int unsigned QueueDepth = bsc_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bsc_pkg::RawW-1:0]    raw_pressure_i,
  input  wire logic [bsc_pkg::RawW-1:0]    raw_temperature_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [bsc_pkg::TempW-1:0] temperature_centi_o,
  output logic        [bsc_pkg::PresW-1:0] pressure_centi_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bsc_pkg::AddrW-1:0]   paddr,
  input  wire logic [bsc_pkg::DataW-1:0]   pwdata,
  output logic      [bsc_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  bsc_pkg::cal_t     cal;
  bsc_pkg::q_stat_t  q_stat;
  bsc_pkg::q_entry_t push_entry;
  bsc_pkg::q_entry_t head_entry;
  logic              push;
  logic              pop;

  // calibration registers
  bsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  // input stage
  bsc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .ref_temp_i        (cal.c5),
    .q_stat_i          (q_stat),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  // decoupling queue
  bsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  // arithmetic pipeline
  bsc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cal_i               (cal),
    .entry_i             (head_entry),
    .q_stat_i            (q_stat),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_centi_o    (pressure_centi_o)
  );

endmodule

`default_nettype wire

[hdl/bsc_checker.sv]
// ----------------------------------------------------------------------------
// bsc_checker
// Port level checks for the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [bsc_pkg::TempW-1:0]   temperature_centi_o,
  input wire logic [bsc_pkg::PresW-1:0]   pressure_centi_o,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [bsc_pkg::AddrW-1:0]   paddr,
  input wire logic [bsc_pkg::DataW-1:0]   pwdata,
  input wire logic [bsc_pkg::DataW-1:0]   prdata,
  input wire logic                        pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(temperature_centi_o) && $stable(pressure_centi_o))
    else $error("output payload changed while stalled");

  // one free output cycle always drains the queue below full
  a_in_unstall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled after an unstalled output cycle");

  // a calibration write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready
      && (paddr[bsc_pkg::AddrW-1:2] < 3'(bsc_pkg::NumCal))
    ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata == {{(bsc_pkg::DataW - bsc_pkg::CalW){1'b0}},
                   $past(pwdata[bsc_pkg::CalW-1:0])})
    else $error("calibration read back mismatch");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire
